// ===== rtl/core/moving_average_filter_assert.svh =====
// Assertion macros for the moving average filter checker.
`ifndef MOVING_AVERAGE_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MAVF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moving average filter: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MAVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moving average filter: next-cycle check failed");

`endif

// ===== rtl/core/mavf_pkg.sv =====
// Package with the constants, types and state codes of the moving average filter.
package mavf_pkg;

    // Sizes of the window store and of the data path.
    localparam int MAX_WINDOW   = 256;
    localparam int SAMPLE_BITS  = 24;
    localparam int MEAN_BITS    = 24;
    localparam int TOTAL_BITS   = 32;
    localparam int LEN_BITS     = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_BITS    = $clog2(MAX_WINDOW);
    localparam int DIV_CNT_BITS = $clog2(TOTAL_BITS);
    localparam int LENGTH_RESET = 10;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_HOLD
    } t_state;

    // Request into the serial divider.
    typedef struct packed {
        logic                         start;
        logic signed [TOTAL_BITS-1:0] dividend;
        logic [LEN_BITS-1:0]          divisor;
    } t_div_req;

    // Result out of the serial divider.
    typedef struct packed {
        logic                  done;
        logic [TOTAL_BITS-1:0] quotient;
    } t_div_res;

endpackage

// ===== rtl/core/moving_average_filter.sv =====
// Top level of the moving average filter: ring store, running total and sequencer.
//
//  Channel   Direction  Handshake                  Payload
//  input     in         i_valid / o_stall          i_sample   (24 bits, signed)
//  output    out        o_valid / i_stall          o_mean     (24 bits, signed)
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (9 bits, window length)
//
// An item passes these steps before the next can be accepted: a read of the oldest sample
// from the store, an update of the total with write-back, a load of the divider, the
// one-bit-per-cycle serial divider, which sets the rate, and a move of the quotient into
// the output register. Reset, and every length write, empties the window through
// per-entry valid bits, with no clearing pass. A stalled result waits in the output
// register while the next word is taken; a second result then waits inside the block and
// the input stalls until the first one leaves. A configuration write on offer holds the
// input off for that cycle.
module moving_average_filter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [mavf_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mavf_pkg::MEAN_BITS-1:0]   o_mean,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mavf_pkg::LEN_BITS-1:0]       i_cfg_data
);

    mavf_pkg::t_state                       r_state, n_state;
    logic [mavf_pkg::MAX_WINDOW-1:0]        r_vld, n_vld;
    logic                                   r_old_vld, n_old_vld;
    logic signed [mavf_pkg::TOTAL_BITS-1:0] r_total, n_total;
    logic [mavf_pkg::SLOT_BITS-1:0]         r_slot, n_slot;
    logic [mavf_pkg::LEN_BITS-1:0]          r_len, n_len;
    logic                                   r_out_valid, n_out_valid;
    logic [mavf_pkg::SAMPLE_BITS-1:0]       r_sample, n_sample;
    logic [mavf_pkg::MEAN_BITS-1:0]         r_mean, n_mean;

    logic                                   rd_en;
    logic                                   wr_en;
    logic                                   div_start;
    logic                                   cfg_wr;
    logic [mavf_pkg::SAMPLE_BITS-1:0]       rd_data;
    logic [mavf_pkg::SAMPLE_BITS-1:0]       old_sample;
    logic signed [mavf_pkg::TOTAL_BITS-1:0] old_ext;
    logic signed [mavf_pkg::TOTAL_BITS-1:0] new_ext;
    logic [mavf_pkg::LEN_BITS-1:0]          slot_inc;
    logic [mavf_pkg::SLOT_BITS-1:0]         slot_next;
    logic [mavf_pkg::LEN_BITS-1:0]          len_sat;
    mavf_pkg::t_div_req                     div_req;
    mavf_pkg::t_div_res                     div_res;

    // Sample store.
    mavf_ram #(
        .WIDTH(mavf_pkg::SAMPLE_BITS),
        .DEPTH(mavf_pkg::MAX_WINDOW)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_slot),
        .i_wr_data(r_sample),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_slot),
        .o_rd_data(rd_data)
    );

    // Serial divider for the mean.
    assign div_req.start    = div_start;
    assign div_req.dividend = r_total;
    assign div_req.divisor  = r_len;

    mavf_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_res  (div_res)
    );

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mavf_pkg::ST_IDLE;
            r_vld       <= '0;
            r_total     <= '0;
            r_slot      <= '0;
            r_len       <= mavf_pkg::LEN_BITS'(mavf_pkg::LENGTH_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vld       <= n_vld;
            r_total     <= n_total;
            r_slot      <= n_slot;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sample  <= n_sample;
        r_old_vld <= n_old_vld;
        r_mean    <= n_mean;
    end

    // Oldest sample reads as zero when its entry has not been written since clearing.
    always_comb begin
        old_sample = r_old_vld ? rd_data : '0;
        old_ext    = {{(mavf_pkg::TOTAL_BITS - mavf_pkg::SAMPLE_BITS)
                       {old_sample[mavf_pkg::SAMPLE_BITS-1]}}, old_sample};
        new_ext    = {{(mavf_pkg::TOTAL_BITS - mavf_pkg::SAMPLE_BITS)
                       {r_sample[mavf_pkg::SAMPLE_BITS-1]}}, r_sample};
    end

    // Ring index advance, wrapping at the window length.
    always_comb begin
        slot_inc  = mavf_pkg::LEN_BITS'(r_slot) + 1'b1;
        slot_next = (slot_inc >= r_len) ? '0 : slot_inc[mavf_pkg::SLOT_BITS-1:0];
    end

    // Length written through the configuration port, held within one and the store depth.
    always_comb begin
        if (i_cfg_data == '0) begin
            len_sat = mavf_pkg::LEN_BITS'(1);
        end else if (i_cfg_data > mavf_pkg::LEN_BITS'(mavf_pkg::MAX_WINDOW)) begin
            len_sat = mavf_pkg::LEN_BITS'(mavf_pkg::MAX_WINDOW);
        end else begin
            len_sat = i_cfg_data;
        end
    end

    assign o_cfg_ready = i_rst_n && (r_state == mavf_pkg::ST_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Sequencer: read, update and write back, divide, then hand the mean over.
    always_comb begin
        n_state     = r_state;
        n_vld       = r_vld;
        n_old_vld   = r_old_vld;
        n_total     = r_total;
        n_slot      = r_slot;
        n_len       = r_len;
        n_out_valid = r_out_valid;
        n_sample    = r_sample;
        n_mean      = r_mean;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        div_start   = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            mavf_pkg::ST_IDLE: begin
                if (i_valid && !o_stall) begin
                    rd_en     = 1'b1;
                    n_sample  = i_sample;
                    n_old_vld = r_vld[r_slot];
                    n_state   = mavf_pkg::ST_UPDATE;
                end
            end
            mavf_pkg::ST_UPDATE: begin
                wr_en         = 1'b1;
                n_vld[r_slot] = 1'b1;
                n_total       = r_total - old_ext + new_ext;
                n_slot        = slot_next;
                n_state       = mavf_pkg::ST_START;
            end
            mavf_pkg::ST_START: begin
                div_start = 1'b1;
                n_state   = mavf_pkg::ST_DIVIDE;
            end
            mavf_pkg::ST_DIVIDE: begin
                if (div_res.done) begin
                    if (!n_out_valid) begin
                        n_out_valid = 1'b1;
                        n_mean      = div_res.quotient[mavf_pkg::MEAN_BITS-1:0];
                        n_state     = mavf_pkg::ST_IDLE;
                    end else begin
                        n_state = mavf_pkg::ST_HOLD;
                    end
                end
            end
            mavf_pkg::ST_HOLD: begin
                if (!n_out_valid) begin
                    n_out_valid = 1'b1;
                    n_mean      = div_res.quotient[mavf_pkg::MEAN_BITS-1:0];
                    n_state     = mavf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mavf_pkg::ST_IDLE;
            end
        endcase

        // A length write empties the window and restarts the ring.
        if (cfg_wr) begin
            n_vld   = '0;
            n_total = '0;
            n_slot  = '0;
            n_len   = len_sat;
        end
    end

    // The input waits while a word is in flight, during reset and while a length write is
    // on offer.
    assign o_stall = !i_rst_n || (r_state != mavf_pkg::ST_IDLE) || i_cfg_valid;
    assign o_valid = r_out_valid;
    assign o_mean  = r_mean;

endmodule

// ===== rtl/core/mavf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module mavf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/mavf_divider.sv =====
// Restoring serial divider: signed total by unsigned length, one quotient bit per cycle.
module mavf_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mavf_pkg::t_div_req i_req,
    output mavf_pkg::t_div_res o_res
);

    logic                                r_busy, n_busy;
    logic                                r_done, n_done;
    logic [mavf_pkg::DIV_CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                                r_neg, n_neg;
    logic [mavf_pkg::LEN_BITS-1:0]       r_div, n_div;
    logic [mavf_pkg::LEN_BITS-1:0]       r_rem, n_rem;
    logic [mavf_pkg::TOTAL_BITS-1:0]     r_quo, n_quo;
    logic [mavf_pkg::LEN_BITS:0]         trial;
    logic                                q_bit;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial = {r_rem, r_quo[mavf_pkg::TOTAL_BITS-1]};
        q_bit = (trial >= {1'b0, r_div});
    end

    // Load the magnitude on start, then step until all quotient bits are formed.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_div  = r_div;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_req.dividend[mavf_pkg::TOTAL_BITS-1];
            n_div  = i_req.divisor;
            n_rem  = '0;
            n_quo  = i_req.dividend[mavf_pkg::TOTAL_BITS-1] ?
                     (~i_req.dividend + 1'b1) : i_req.dividend;
        end else if (r_busy) begin
            n_rem = q_bit ? mavf_pkg::LEN_BITS'(trial - {1'b0, r_div})
                          : trial[mavf_pkg::LEN_BITS-1:0];
            n_quo = {r_quo[mavf_pkg::TOTAL_BITS-2:0], q_bit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == mavf_pkg::DIV_CNT_BITS'(mavf_pkg::TOTAL_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Signed quotient, truncated toward zero.
    assign o_res.done     = r_done;
    assign o_res.quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

// ===== rtl/core/mavf_checker.sv =====
// Port-level checker for the moving average filter, bound to the top level.
`include "moving_average_filter_assert.svh"

module mavf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [mavf_pkg::MEAN_BITS-1:0]      o_mean,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready
);

    logic in_acc;

    assign in_acc = i_valid && !o_stall;

    // An accepted word keeps the block busy in the following cycle.
    `MAVF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_stall)

    // A result never appears in the cycle right after its word was taken.
    `MAVF_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, in_acc, !$rose(o_valid))

    // A new result only comes out of a busy block.
    `MAVF_ASSERT_NOW(a_result_from_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_stall))

    // A stalled result stays and holds its value.
    `MAVF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_mean))

    // A length write and an input word are never taken at the same edge.
    `MAVF_ASSERT_NOW(a_cfg_alone, i_clk, i_rst_n, i_cfg_valid && o_cfg_ready, !in_acc)

endmodule

bind moving_average_filter mavf_checker u_mavf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_mean     (o_mean),
    .i_cfg_valid(i_cfg_valid),
    .o_cfg_ready(o_cfg_ready)
);
